/* design/dpsm_pkg.sv */
// ----------------------------------------------------------------------------
// dpsm_pkg
// action codes and shared types of the session mailbox
// ----------------------------------------------------------------------------
package dpsm_pkg;

   typedef enum logic [2:0] {
      ACT_PUSH_NORMAL = 3'd0,
      ACT_PUSH_HALT   = 3'd1,
      ACT_POP         = 3'd2,
      ACT_DONE_NORMAL = 3'd3,
      ACT_DONE_HALT   = 3'd4,
      ACT_QUERY       = 3'd5,
      ACT_CLEAR       = 3'd6,
      ACT_NONE        = 3'd7
   } action_type;

   localparam logic [63:0] SEQ_MAX = 64'hFFFF_FFFF_FFFF_FFFF;

   // completion log slots, indexed by the low sequence bits
   localparam int HISTORY_DEPTH = 16;

endpackage

/* design/dpsm_ram.sv */
// ----------------------------------------------------------------------------
// dpsm_ram
// generic ram with one write port, one read port and registered read
// ----------------------------------------------------------------------------
module dpsm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

/* design/dual_priority_session_mailbox.sv */
// ----------------------------------------------------------------------------
// dual_priority_session_mailbox
// push, pop, complete and query over two command rings and a completion log
// pop walks the halt ring, then the normal ring unless the session is halted,
// one entry at a time; a power-off completion flushes the normal ring and
// walks the halt ring; the next word is taken once the response is registered
// synchronous reset empties rings and sets the allocator to 1; a clearing pass
// then zeroes every completion log slot before req is taken
// ----------------------------------------------------------------------------
module dual_priority_session_mailbox
   import dpsm_pkg::*;
#(
   parameter int RING_SLOTS    = 16,
   parameter int PAYLOAD_BITS  = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_action,
   input  logic [31:0] req_frame_in,
   input  logic [63:0] req_session,
   input  logic [63:0] req_sequence_in,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_ok,
   output logic [31:0] rsp_frame_out,
   output logic        rsp_is_power_off,
   output logic [63:0] rsp_sequence_out
);

   localparam int RW = (RING_SLOTS > 1) ? $clog2(RING_SLOTS) : 1;
   localparam int HW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
   localparam int HD = 1 << HW;
   localparam int PB = (PAYLOAD_BITS < 32) ? PAYLOAD_BITS : 32;
   localparam int EW = PB + 128;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_DECODE, S_HALT_RD, S_HALT_CHK, S_NORM_RD, S_NORM_CHK,
      S_FLUSH_RD, S_FLUSH_CHK, S_QUERY_RD, S_QUERY_CHK, S_RESP
   } state_type;

   state_type        state_ff;
   logic [2:0]       act_ff;
   logic [31:0]      frame_ff;
   logic [63:0]      sess_ff, seq_ff;
   logic [63:0]      next_seq_ff, emerg_ff;
   logic [RW-1:0]    nh_ff, nt_ff, hh_ff, ht_ff;
   logic [HW:0]      clr_ff;
   logic             ok_ff, po_ff, rv_ff;
   logic [31:0]      fo_ff;
   logic [63:0]      so_ff;

   logic             n_we, h_we, d_we;
   logic [RW-1:0]    n_rd, h_rd;
   logic [HW-1:0]    d_wa, d_ra;
   logic [63:0]      d_wd, d_q;
   logic [EW-1:0]    e_wd, n_q, h_q;

   function automatic logic [RW-1:0] wrap(input logic [RW-1:0] i);
      logic [RW:0] t;
      t = {1'b0, i} + 1'b1;
      return (t == (RW+1)'(RING_SLOTS)) ? '0 : t[RW-1:0];
   endfunction

   assign e_wd = {frame_ff[PB-1:0], next_seq_ff, sess_ff};

   dpsm_ram #(.WIDTH(EW), .DEPTH(RING_SLOTS)) u_norm (
      .clock, .wr_en(n_we), .wr_addr(nh_ff), .wr_data(e_wd), .rd_addr(n_rd),
      .rd_data(n_q));
   dpsm_ram #(.WIDTH(EW), .DEPTH(RING_SLOTS)) u_halt (
      .clock, .wr_en(h_we), .wr_addr(hh_ff), .wr_data(e_wd), .rd_addr(h_rd),
      .rd_data(h_q));
   dpsm_ram #(.WIDTH(64), .DEPTH(HD)) u_done (
      .clock, .wr_en(d_we), .wr_addr(d_wa), .wr_data(d_wd), .rd_addr(d_ra),
      .rd_data(d_q));

   logic [63:0] n_sess, h_sess, n_seq, h_seq;
   logic [31:0] n_fr, h_fr;
   logic        seq_ok, n_full, h_full;

   assign n_sess = n_q[63:0];
   assign n_seq  = n_q[127:64];
   assign n_fr   = 32'(n_q[EW-1:128]);
   assign h_sess = h_q[63:0];
   assign h_seq  = h_q[127:64];
   assign h_fr   = 32'(h_q[EW-1:128]);
   assign seq_ok = next_seq_ff != SEQ_MAX;
   assign n_full = wrap(nh_ff) == nt_ff;
   assign h_full = wrap(hh_ff) == ht_ff;
   assign n_rd   = nt_ff;
   assign h_rd   = ht_ff;
   assign d_ra   = HW'(seq_ff % HD);

   always_comb begin
      n_we = 1'b0;
      h_we = 1'b0;
      d_we = 1'b0;
      d_wa = HW'(seq_ff % HD);
      d_wd = seq_ff;
      unique case (state_ff)
         S_CLEAR: begin
            d_we = 1'b1;
            d_wa = clr_ff[HW-1:0];
            d_wd = '0;
         end
         S_DECODE: begin
            if (act_ff == ACT_PUSH_NORMAL) begin
               n_we = sess_ff != '0 && emerg_ff != sess_ff && seq_ok && !n_full;
            end
            if (act_ff == ACT_PUSH_HALT) begin
               h_we = sess_ff != '0 && seq_ok && !h_full;
            end
            if (act_ff == ACT_DONE_NORMAL || act_ff == ACT_DONE_HALT) begin
               d_we = seq_ff != '0;
            end
         end
         S_FLUSH_CHK: begin
            d_we = h_sess == sess_ff && h_seq != '0;
            d_wa = HW'(h_seq % HD);
            d_wd = h_seq;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_CLEAR;
         clr_ff      <= '0;
         nh_ff       <= '0;
         nt_ff       <= '0;
         hh_ff       <= '0;
         ht_ff       <= '0;
         next_seq_ff <= 64'd1;
         emerg_ff    <= '0;
         rv_ff       <= 1'b0;
      end else begin
         unique case (state_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == (HW+1)'(HD - 1)) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (req_valid) begin
                  act_ff   <= req_action;
                  frame_ff <= req_frame_in;
                  sess_ff  <= req_session;
                  seq_ff   <= req_sequence_in;
                  ok_ff    <= 1'b0;
                  po_ff    <= 1'b0;
                  fo_ff    <= '0;
                  so_ff    <= '0;
                  state_ff <= S_DECODE;
               end
            end
            S_DECODE: begin
               state_ff <= S_RESP;
               case (act_ff)
                  ACT_PUSH_NORMAL: begin
                     if (sess_ff != '0 && emerg_ff != sess_ff && seq_ok) begin
                        next_seq_ff <= next_seq_ff + 1'b1;
                        if (!n_full) begin
                           nh_ff <= wrap(nh_ff);
                           ok_ff <= 1'b1;
                           so_ff <= next_seq_ff;
                        end
                     end
                  end
                  ACT_PUSH_HALT: begin
                     if (sess_ff != '0) begin
                        emerg_ff <= sess_ff;
                        if (seq_ok) begin
                           next_seq_ff <= next_seq_ff + 1'b1;
                           if (!h_full) begin
                              hh_ff <= wrap(hh_ff);
                              ok_ff <= 1'b1;
                              so_ff <= next_seq_ff;
                           end
                        end
                     end
                  end
                  ACT_POP: state_ff <= S_HALT_RD;
                  ACT_DONE_HALT: begin
                     nt_ff    <= nh_ff;
                     state_ff <= S_FLUSH_RD;
                  end
                  ACT_QUERY: state_ff <= S_QUERY_RD;
                  ACT_CLEAR: begin
                     ht_ff    <= hh_ff;
                     nt_ff    <= nh_ff;
                     emerg_ff <= '0;
                  end
                  default: ;
               endcase
            end
            S_HALT_RD: begin
               if (ht_ff == hh_ff) begin
                  state_ff <= (emerg_ff != sess_ff) ? S_NORM_RD : S_RESP;
               end else begin
                  state_ff <= S_HALT_CHK;
               end
            end
            S_HALT_CHK: begin
               ht_ff <= wrap(ht_ff);
               if (h_sess == sess_ff) begin
                  ok_ff    <= 1'b1;
                  po_ff    <= 1'b1;
                  fo_ff    <= h_fr;
                  so_ff    <= h_seq;
                  state_ff <= S_RESP;
               end else begin
                  state_ff <= S_HALT_RD;
               end
            end
            S_NORM_RD: state_ff <= (nt_ff == nh_ff) ? S_RESP : S_NORM_CHK;
            S_NORM_CHK: begin
               nt_ff <= wrap(nt_ff);
               if (n_sess == sess_ff) begin
                  ok_ff    <= 1'b1;
                  fo_ff    <= n_fr;
                  so_ff    <= n_seq;
                  state_ff <= S_RESP;
               end else begin
                  state_ff <= S_NORM_RD;
               end
            end
            S_FLUSH_RD: begin
               if (ht_ff == hh_ff) begin
                  if (emerg_ff == sess_ff) begin
                     emerg_ff <= '0;
                  end
                  state_ff <= S_RESP;
               end else begin
                  state_ff <= S_FLUSH_CHK;
               end
            end
            S_FLUSH_CHK: begin
               ht_ff    <= wrap(ht_ff);
               state_ff <= S_FLUSH_RD;
            end
            S_QUERY_RD: state_ff <= S_QUERY_CHK;
            S_QUERY_CHK: begin
               ok_ff    <= seq_ff != '0 && d_q == seq_ff;
               state_ff <= S_RESP;
            end
            S_RESP: begin
               if (!rv_ff || !rsp_stall) begin
                  rv_ff            <= 1'b1;
                  rsp_ok           <= ok_ff;
                  rsp_frame_out    <= fo_ff;
                  rsp_is_power_off <= po_ff;
                  rsp_sequence_out <= so_ff;
                  state_ff         <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
         if (rv_ff && !rsp_stall && !(state_ff == S_RESP)) begin
            rv_ff <= 1'b0;
         end
      end
   end

   assign req_stall = state_ff != S_IDLE;
   assign rsp_valid = rv_ff;

endmodule

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the dual priority session mailbox: a directed table
// of words, then random push/pop/complete/query/clear words; each response is
// checked per field against a typed table reply or the in-bench predictor
// ----------------------------------------------------------------------------
module testbench
   import dpsm_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SLOTS       = 16;
   localparam int HIST        = 16;
   localparam int RANDOM_GOAL = 1850;
   localparam int QUIET_AFTER = 1650;
   localparam int CYCLE_LIMIT = 2000000;

   typedef struct packed {
      logic        ok;
      logic [31:0] frame;
      logic        power_off;
      logic [63:0] seq;
   } reply_type;

   typedef struct {
      action_type  act;
      logic [31:0] frame;
      logic [63:0] sess;
      logic [63:0] seq;
      bit          typed;
      reply_type   reply;
   } row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [2:0]  req_action = 3'd0;
   logic [31:0] req_frame_in = '0;
   logic [63:0] req_session = '0;
   logic [63:0] req_sequence_in = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_ok;
   logic [31:0] rsp_frame_out;
   logic        rsp_is_power_off;
   logic [63:0] rsp_sequence_out;

   // predictor state
   logic [31:0] ring_n_frame [SLOTS];
   logic [63:0] ring_n_seq   [SLOTS];
   logic [63:0] ring_n_sess  [SLOTS];
   logic [31:0] ring_h_frame [SLOTS];
   logic [63:0] ring_h_seq   [SLOTS];
   logic [63:0] ring_h_sess  [SLOTS];
   int          n_head, n_tail, h_head, h_tail;
   logic [63:0] seq_alloc;
   logic [63:0] alarm_session;
   logic [63:0] done_log [HIST];

   reply_type   pending_replies [$];
   int          errors = 0;
   int          items = 0;
   longint      cycles = 0;
   bit          quiet = 1'b0;
   bit          hold_wanted = 1'b0;

   dual_priority_session_mailbox dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_action(req_action),
      .req_frame_in(req_frame_in), .req_session(req_session),
      .req_sequence_in(req_sequence_in),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_ok(rsp_ok),
      .rsp_frame_out(rsp_frame_out), .rsp_is_power_off(rsp_is_power_off),
      .rsp_sequence_out(rsp_sequence_out)
   );

   always #2 clock = ~clock;

   function automatic logic [63:0] alloc_seq();
      logic [63:0] s;
      s = seq_alloc;
      if (s == SEQ_MAX) return 64'd0;
      seq_alloc = s + 64'd1;
      return s;
   endfunction

   function automatic void log_done(logic [63:0] s);
      if (s != '0) done_log[s % HIST] = s;
   endfunction

   function automatic reply_type mailbox_predict(action_type act, logic [31:0] fr,
                                                 logic [63:0] ss, logic [63:0] sq);
      reply_type r;
      logic [63:0] s;
      int nx;
      r = '0;
      case (act)
         ACT_PUSH_NORMAL: begin
            if (ss != '0 && alarm_session != ss) begin
               s = alloc_seq();
               nx = (n_head + 1) % SLOTS;
               if (s != '0 && nx != n_tail) begin
                  ring_n_frame[n_head] = fr;
                  ring_n_seq[n_head] = s;
                  ring_n_sess[n_head] = ss;
                  n_head = nx;
                  r.ok = 1'b1;
                  r.seq = s;
               end
            end
         end
         ACT_PUSH_HALT: begin
            if (ss != '0) begin
               alarm_session = ss;
               s = alloc_seq();
               nx = (h_head + 1) % SLOTS;
               if (s != '0 && nx != h_tail) begin
                  ring_h_frame[h_head] = fr;
                  ring_h_seq[h_head] = s;
                  ring_h_sess[h_head] = ss;
                  h_head = nx;
                  r.ok = 1'b1;
                  r.seq = s;
               end
            end
         end
         ACT_POP: begin
            while (h_tail != h_head) begin
               nx = h_tail;
               h_tail = (h_tail + 1) % SLOTS;
               if (ring_h_sess[nx] == ss) begin
                  r = '{1'b1, ring_h_frame[nx], 1'b1, ring_h_seq[nx]};
                  break;
               end
            end
            if (!r.ok && alarm_session != ss) begin
               while (n_tail != n_head) begin
                  nx = n_tail;
                  n_tail = (n_tail + 1) % SLOTS;
                  if (ring_n_sess[nx] == ss) begin
                     r = '{1'b1, ring_n_frame[nx], 1'b0, ring_n_seq[nx]};
                     break;
                  end
               end
            end
         end
         ACT_DONE_NORMAL: log_done(sq);
         ACT_DONE_HALT: begin
            log_done(sq);
            n_tail = n_head;
            while (h_tail != h_head) begin
               if (ring_h_sess[h_tail] == ss) log_done(ring_h_seq[h_tail]);
               h_tail = (h_tail + 1) % SLOTS;
            end
            if (alarm_session == ss) alarm_session = '0;
         end
         ACT_QUERY: r.ok = (sq != '0 && done_log[sq % HIST] == sq);
         ACT_CLEAR: begin
            h_tail = h_head;
            n_tail = n_head;
            alarm_session = '0;
         end
         default: ;
      endcase
      return r;
   endfunction

   task automatic send_word(action_type act, logic [31:0] fr, logic [63:0] ss,
                            logic [63:0] sq, bit typed, reply_type typed_reply);
      reply_type r;
      req_valid <= 1'b1;
      req_action <= act;
      req_frame_in <= fr;
      req_session <= ss;
      req_sequence_in <= sq;
      do @(posedge clock); while (req_stall);
      r = mailbox_predict(act, fr, ss, sq);
      pending_replies.push_back(typed ? typed_reply : r);
      items++;
      if (items == 900) hold_wanted = 1'b1;
      if (items > QUIET_AFTER) quiet = 1'b1;
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
   endtask

   function automatic logic [63:0] pick_session();
      case ($urandom_range(0, 9))
         0: return 64'd0;
         1: return SEQ_MAX;
         2: return {$urandom, $urandom};
         default: return 64'($urandom_range(1, 3));
      endcase
   endfunction

   function automatic logic [63:0] pick_sequence();
      case ($urandom_range(0, 9))
         0, 1: return 64'd0;
         2, 3, 4: return {$urandom, $urandom};
         default: return seq_alloc - 64'($urandom_range(1, 24));
      endcase
   endfunction

   // response checking
   always @(posedge clock) begin
      reply_type got, want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_ok, rsp_frame_out, rsp_is_power_off, rsp_sequence_out};
         if (pending_replies.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected word: ok=%0b frame=%h po=%0b seq=%h",
                                       got.ok, got.frame, got.power_off, got.seq);
         end else begin
            want = pending_replies.pop_front();
            if (got !== want) begin
               errors++;
               if (errors <= 10)
                  $display({"mismatch: exp ok=%0b frame=%h po=%0b seq=%h, ",
                            "got ok=%0b frame=%h po=%0b seq=%h"},
                           want.ok, want.frame, want.power_off, want.seq,
                           got.ok, got.frame, got.power_off, got.seq);
            end
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // receiver stall
   initial begin
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_wanted) begin
            hold_wanted = 1'b0;
            rsp_stall <= 1'b1;
            repeat (400) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 11)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         @(posedge clock);
      end
   end

   initial begin
      row_type table_rows [$];
      reply_type z;
      logic [63:0] ss;
      int burst;
      z = '0;
      n_head = 0; n_tail = 0; h_head = 0; h_tail = 0;
      seq_alloc = 64'd1;
      alarm_session = '0;
      foreach (done_log[i]) done_log[i] = '0;

      table_rows = '{
         '{ACT_QUERY,       32'h0,        64'd0,   64'd0,   1'b1, '0},
         '{ACT_POP,         32'h0,        64'd0,   64'd0,   1'b1, '0},
         '{ACT_PUSH_NORMAL, 32'h1234,     64'd0,   64'd9,   1'b1, '0},
         '{ACT_PUSH_NORMAL, 32'hFFFFFFFF, 64'd5,   64'd0,   1'b1,
           '{1'b1, 32'h0, 1'b0, 64'd1}},
         '{ACT_PUSH_HALT,   32'h55,       64'd0,   64'd0,   1'b1, '0},
         '{ACT_PUSH_HALT,   32'h0,        SEQ_MAX, 64'd0,   1'b1,
           '{1'b1, 32'h0, 1'b0, 64'd2}},
         '{ACT_PUSH_NORMAL, 32'hA5A5A5A5, SEQ_MAX, 64'd0,   1'b1, '0},
         '{ACT_POP,         32'h0,        SEQ_MAX, 64'd0,   1'b1,
           '{1'b1, 32'h0, 1'b1, 64'd2}},
         '{ACT_POP,         32'h0,        64'd5,   64'd0,   1'b1,
           '{1'b1, 32'hFFFFFFFF, 1'b0, 64'd1}},
         '{ACT_DONE_NORMAL, 32'h0,        64'd0,   64'd1,   1'b1, '0},
         '{ACT_QUERY,       32'h0,        64'd0,   64'd1,   1'b1,
           '{1'b1, 32'h0, 1'b0, 64'd0}},
         '{ACT_QUERY,       32'h0,        64'd0,   64'd17,  1'b1, '0},
         '{ACT_DONE_NORMAL, 32'h0,        64'd0,   SEQ_MAX, 1'b1, '0},
         '{ACT_QUERY,       32'h0,        64'd0,   SEQ_MAX, 1'b1,
           '{1'b1, 32'h0, 1'b0, 64'd0}},
         '{ACT_PUSH_HALT,   32'h77,       64'd7,   64'd0,   1'b0, '0},
         '{ACT_PUSH_NORMAL, 32'h88,       64'd8,   64'd0,   1'b0, '0},
         '{ACT_PUSH_HALT,   32'h99,       64'd8,   64'd0,   1'b0, '0},
         '{ACT_POP,         32'h0,        64'd8,   64'd0,   1'b0, '0},
         '{ACT_DONE_HALT,   32'h0,        64'd7,   64'd0,   1'b0, '0},
         '{ACT_QUERY,       32'h0,        64'd0,   64'd3,   1'b0, '0},
         '{ACT_PUSH_NORMAL, 32'h1,        64'd8,   64'd0,   1'b0, '0},
         '{ACT_CLEAR,       32'h0,        64'd0,   64'd0,   1'b1, '0},
         '{ACT_POP,         32'h0,        64'd8,   64'd0,   1'b0, '0},
         '{ACT_NONE,        32'hFFFFFFFF, SEQ_MAX, SEQ_MAX, 1'b1, '0}
      };

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (table_rows[i])
         send_word(table_rows[i].act, table_rows[i].frame, table_rows[i].sess,
                   table_rows[i].seq, table_rows[i].typed, table_rows[i].reply);

      while (items < RANDOM_GOAL) begin
         case ($urandom_range(0, 9))
            0, 1: begin
               // push a burst that can fill the normal ring past full, then pop part of it
               ss = 64'($urandom_range(1, 3));
               burst = $urandom_range(4, 18);
               repeat (burst) send_word(ACT_PUSH_NORMAL, $urandom, ss, '0, 1'b0, z);
               repeat ($urandom_range(1, burst))
                  send_word(ACT_POP, '0, ($urandom_range(0, 3) == 0) ? pick_session() : ss,
                            '0, 1'b0, z);
            end
            2: begin
               // emergency sequence with a power-off completion, then a query
               ss = pick_session();
               repeat ($urandom_range(1, 17))
                  send_word(ACT_PUSH_HALT, $urandom,
                            ($urandom_range(0, 3) == 0) ? pick_session() : ss,
                            '0, 1'b0, z);
               send_word(ACT_PUSH_NORMAL, $urandom, pick_session(), '0, 1'b0, z);
               if ($urandom_range(0, 1)) send_word(ACT_POP, '0, ss, '0, 1'b0, z);
               send_word(ACT_DONE_HALT, '0, ss, pick_sequence(), 1'b0, z);
               send_word(ACT_QUERY, '0, '0, pick_sequence(), 1'b0, z);
            end
            default: begin
               case ($urandom_range(0, 19))
                  0, 1, 2, 3, 4, 5:
                     send_word(ACT_PUSH_NORMAL, $urandom, pick_session(), pick_sequence(),
                               1'b0, z);
                  6: send_word(ACT_PUSH_HALT, $urandom, pick_session(), pick_sequence(),
                               1'b0, z);
                  7, 8, 9, 10: send_word(ACT_POP, $urandom, pick_session(), pick_sequence(),
                                         1'b0, z);
                  11, 12: send_word(ACT_DONE_NORMAL, $urandom, pick_session(),
                                    pick_sequence(), 1'b0, z);
                  13: send_word(ACT_DONE_HALT, $urandom, pick_session(), pick_sequence(),
                                1'b0, z);
                  14, 15, 16: send_word(ACT_QUERY, $urandom, pick_session(),
                                        pick_sequence(), 1'b0, z);
                  17: send_word(ACT_CLEAR, $urandom, pick_session(), pick_sequence(),
                                1'b0, z);
                  default: send_word(ACT_NONE, $urandom, pick_session(), pick_sequence(),
                                     1'b0, z);
               endcase
            end
         endcase
      end

      req_valid <= 1'b0;
      while (pending_replies.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
